@@ src/wca_pkg.sv @@
// Shared types and constants for the WCA pair potential/force pipeline.
// No dependencies; imported by wca_mul, wca_div and the top level.
package wca_pkg;

  // Field and arithmetic widths
  localparam int DIST_W     = 32;
  localparam int OUT_W      = 48;
  localparam int LIMB_W     = 32;
  localparam int NUM_W      = 64;
  localparam int DEN_W      = 32;
  localparam int CUT_W      = 25;
  localparam int CUT_PROD_W = CUT_W + DIST_W;
  localparam int DSH_W      = DIST_W + 24;
  localparam int WIDE_W     = 128;
  localparam int CFG_IDX_W  = 8;

  // Cutoff factor 1.259921 in Q1.24
  localparam logic [CUT_W-1:0] CUT_Q24 = 25'd21137967;
  // 0.5 in Q32.32
  localparam logic [63:0] HALF_Q32 = 64'h0000_0000_8000_0000;
  localparam logic [OUT_W-1:0] OUT_MAX = '1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SIGMA_SQ = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EPSILON  = 8'd1;

  // Pipeline depths: divider front end, then the multiply chain
  localparam int DIV_LAT  = NUM_W + 1;
  localparam int POST_LAT = 16;
  localparam int TOT_LAT  = DIV_LAT + POST_LAT;

  // Per-item context carried down the multiply chain
  typedef struct packed {
    logic              zero;
    logic              skip;
    logic              sat;
    logic              esat;
    logic              fsat;
    logic              flag;
    logic [63:0]       q;
    logic [63:0]       q2;
    logic [63:0]       s6;
    logic [63:0]       u;
    logic [63:0]       rr;
    logic [63:0]       b;
    logic [WIDE_W-1:0] y48;
    logic [OUT_W-1:0]  energy;
    logic [OUT_W-1:0]  force_factor;
  } ctx_t;

  // Sideband beside the dividers
  typedef struct packed {
    logic zero;
    logic skip;
  } side_t;

endpackage

@@ src/wca_mul.sv @@
// Two-stage pipelined multiplier: 32x32 partial products, then their sum.
// Depends on wca_pkg (LIMB_W).
module wca_mul
  import wca_pkg::*;
#(
  parameter int AW = 64,
  parameter int BW = 64
) (
  input  logic             clk,
  input  logic             en,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic [AW+BW-1:0] p
);

  localparam int NA  = AW / LIMB_W;
  localparam int NB  = BW / LIMB_W;
  localparam int PW  = AW + BW;
  localparam int PPW = 2 * LIMB_W;

  logic [PPW-1:0] pp_r [0:NA*NB-1];
  logic [PW-1:0]  sum;
  logic [PW-1:0]  p_r;

  // Stage 1: partial products
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_r[i*NB+j] <= PPW'(a[i*LIMB_W +: LIMB_W]) * PPW'(b[j*LIMB_W +: LIMB_W]);
        end
      end
    end
  end

  // Stage 2: aligned sum
  always_comb begin
    sum = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        sum = sum + (PW'(pp_r[i*NB+j]) << ((i + j) * LIMB_W));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= sum;
    end
  end

  assign p = p_r;

endmodule

@@ src/wca_div.sv @@
// Pipelined restoring divider, one quotient bit per stage (64-bit / 32-bit).
// Depends on wca_pkg (NUM_W, DEN_W).
module wca_div
  import wca_pkg::*;
(
  input  logic             clk,
  input  logic             en,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo
);

  // nq holds the unused dividend bits shifting out and quotient bits shifting in
  logic [DEN_W-1:0] rem_r  [0:NUM_W];
  logic [NUM_W-1:0] nq_r   [0:NUM_W];
  logic [DEN_W-1:0] den_r  [0:NUM_W];
  logic [DEN_W-1:0] rem_nxt[1:NUM_W];
  logic [NUM_W-1:0] nq_nxt [1:NUM_W];
  logic [DEN_W:0]   trial  [1:NUM_W];
  logic             ge     [1:NUM_W];

  // One trial subtract per stage
  always_comb begin
    for (int k = 1; k <= NUM_W; k++) begin
      trial[k]   = {rem_r[k-1], nq_r[k-1][NUM_W-1]};
      ge[k]      = trial[k] >= {1'b0, den_r[k-1]};
      rem_nxt[k] = ge[k] ? DEN_W'(trial[k] - {1'b0, den_r[k-1]}) : trial[k][DEN_W-1:0];
      nq_nxt[k]  = {nq_r[k-1][NUM_W-2:0], ge[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= '0;
      nq_r[0]  <= num;
      den_r[0] <= den;
      for (int k = 1; k <= NUM_W; k++) begin
        rem_r[k] <= rem_nxt[k];
        nq_r[k]  <= nq_nxt[k];
        den_r[k] <= den_r[k-1];
      end
    end
  end

  assign quo = nq_r[NUM_W];

endmodule

@@ src/wca_pair_potential_force_unit.sv @@
// Top level of the WCA pair kernel: config registers, cutoff test, dividers,
// multiply chain and output stage. Depends on wca_pkg, wca_div, wca_mul.
//
//  channel | dir | payload (low bit first)                  | accepted when
//  in_     | in  | tdata: dist_sq[31:0]                     | in_tvalid & in_tready
//  out_    | out | tdata: energy[47:0], force_factor[95:48] | out_tvalid & out_tready
//          |     | tuser: saturated                         |
//  cfg_    | in  | index, data: sigma_sq(0), epsilon(1)     | cfg_valid & cfg_ready
//
// One item per clock unless the output stalls; each item passes TOT_LAT = 81
// register stages. The depth is set by the two 65-stage bit-per-cycle dividers
// (1/r^2 and sigma^2/r^2) and the 16-stage multiply chain of seven two-stage
// multipliers behind them. The whole pipeline
// advances together: it stalls only while a result sits unaccepted at the output.
// Synchronous active-low reset clears the valid line and restores the
// registers to 1.0; config is always ready.
module wca_pair_potential_force_unit
  import wca_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [DIST_W-1:0]    in_tdata,   // dist_sq[31:0]
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [2*OUT_W-1:0]   out_tdata,  // energy[47:0], force_factor[95:48]
  output logic                 out_tuser,  // saturated
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DIST_W-1:0]    cfg_data
);

  // Stage positions in the multiply chain
  localparam int ST_Q2  = 3;
  localparam int ST_S6  = 6;
  localparam int ST_U   = 7;
  localparam int ST_EPS = 12;
  localparam int ST_Y48 = 15;
  localparam int LAST   = POST_LAT;

  logic [DIST_W-1:0]     sigma_sq_r, epsilon_r;
  logic                  en;
  logic [TOT_LAT-1:0]    vld_r;
  logic [CUT_PROD_W-1:0] cut_r;
  logic [DSH_W-1:0]      dsh_r;
  side_t                 sb_r [0:DIV_LAT-1];
  logic [NUM_W-1:0]      div_q_quo, div_r_quo;
  ctx_t                  ctx0;
  ctx_t                  ctx_r   [1:LAST];
  ctx_t                  ctx_nxt [1:LAST];
  logic [WIDE_W-1:0]     mul_a_p, mul_b_p, mul_c_p, mul_d_p, mul_e_p, mul_f_p, mul_g_p;

  // Config registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sigma_sq_r <= 32'h0100_0000;
      epsilon_r  <= 32'h0100_0000;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SIGMA_SQ: sigma_sq_r <= cfg_data;
        REG_EPSILON:  epsilon_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Global advance and valid line
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;
  assign out_tvalid = vld_r[TOT_LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[TOT_LAT-2:0], in_tvalid};
    end
  end

  // Cutoff test and special-case flags beside the dividers
  always_ff @(posedge clk) begin
    if (en) begin
      cut_r         <= CUT_PROD_W'(CUT_Q24) * CUT_PROD_W'(sigma_sq_r);
      dsh_r         <= {in_tdata, 24'b0};
      sb_r[0].zero  <= in_tdata == '0;
      sb_r[0].skip  <= epsilon_r == '0;
      sb_r[1].zero  <= sb_r[0].zero;
      sb_r[1].skip  <= sb_r[0].skip || ({1'b0, dsh_r} > cut_r);
      for (int k = 2; k < DIV_LAT; k++) begin
        sb_r[k] <= sb_r[k-1];
      end
    end
  end

  // sigma^2/r^2 in Q32.32 and 1/r^2 in Q24.40
  wca_div u_div_q (
    .clk (clk),
    .en  (en),
    .num ({sigma_sq_r, 32'b0}),
    .den (in_tdata),
    .quo (div_q_quo)
  );

  wca_div u_div_r (
    .clk (clk),
    .en  (en),
    .num ('1),
    .den (in_tdata),
    .quo (div_r_quo)
  );

  always_comb begin
    ctx0      = '0;
    ctx0.zero = sb_r[DIV_LAT-1].zero;
    ctx0.skip = sb_r[DIV_LAT-1].skip;
    ctx0.q    = div_q_quo;
    ctx0.rr   = div_r_quo;
  end

  // Multipliers; each output lines up two stages after its operands
  wca_mul #(.AW(64), .BW(64)) u_mul_a (
    .clk(clk), .en(en), .a(ctx0.q), .b(ctx0.q), .p(mul_a_p));
  wca_mul #(.AW(64), .BW(64)) u_mul_b (
    .clk(clk), .en(en), .a(ctx_r[ST_Q2].q2), .b(ctx_r[ST_Q2].q), .p(mul_b_p));
  wca_mul #(.AW(64), .BW(64)) u_mul_c (
    .clk(clk), .en(en), .a(ctx_r[ST_U].u), .b(ctx_r[ST_U].u), .p(mul_c_p));
  wca_mul #(.AW(64), .BW(64)) u_mul_d (
    .clk(clk), .en(en), .a(ctx_r[ST_U].s6), .b(ctx_r[ST_U].u), .p(mul_d_p));
  wca_mul #(.AW(96), .BW(32)) u_mul_e (
    .clk(clk), .en(en), .a(mul_c_p[127:32]), .b(epsilon_r), .p(mul_e_p));
  wca_mul #(.AW(96), .BW(32)) u_mul_f (
    .clk(clk), .en(en), .a(mul_d_p[127:32]), .b(epsilon_r), .p(mul_f_p));
  wca_mul #(.AW(64), .BW(64)) u_mul_g (
    .clk(clk), .en(en), .a(ctx_r[ST_EPS].b), .b(ctx_r[ST_EPS].rr), .p(mul_g_p));

  // Context line with the per-stage updates
  always_comb begin
    ctx_nxt[1] = ctx0;
    for (int k = 2; k <= LAST; k++) begin
      ctx_nxt[k] = ctx_r[k-1];
    end

    // q2 = q*q in Q32.32
    ctx_nxt[ST_Q2].q2  = mul_a_p[95:32];
    ctx_nxt[ST_Q2].sat = |mul_a_p[127:96];

    // s6 = q2*q in Q32.32
    ctx_nxt[ST_S6].s6  = mul_b_p[95:32];
    ctx_nxt[ST_S6].sat = ctx_r[ST_S6-1].sat || (|mul_b_p[127:96]);

    // u = s6 - 0.5, floored at zero
    ctx_nxt[ST_U].u = (ctx_r[ST_U-1].s6 > HALF_Q32) ? ctx_r[ST_U-1].s6 - HALF_Q32 : '0;

    // epsilon scaling: energy in Q32.16, force numerator B in Q35.29
    ctx_nxt[ST_EPS].esat   = |mul_e_p[127:86];
    ctx_nxt[ST_EPS].energy = mul_e_p[85:38];
    ctx_nxt[ST_EPS].fsat   = |mul_f_p[127:91];
    ctx_nxt[ST_EPS].b      = mul_f_p[90:27];

    // times 1/r^2, then times 48
    ctx_nxt[ST_Y48].fsat = ctx_r[ST_Y48-1].fsat || (|mul_g_p[127:122]);
    ctx_nxt[ST_Y48].y48  = (mul_g_p << 5) + (mul_g_p << 4);

    // Final selection of special cases and saturation
    if (ctx_r[LAST-1].zero) begin
      ctx_nxt[LAST].energy       = OUT_MAX;
      ctx_nxt[LAST].force_factor = OUT_MAX;
      ctx_nxt[LAST].flag         = 1'b1;
    end else if (ctx_r[LAST-1].skip) begin
      ctx_nxt[LAST].energy       = '0;
      ctx_nxt[LAST].force_factor = '0;
      ctx_nxt[LAST].flag         = 1'b0;
    end else if (ctx_r[LAST-1].sat) begin
      ctx_nxt[LAST].energy       = OUT_MAX;
      ctx_nxt[LAST].force_factor = OUT_MAX;
      ctx_nxt[LAST].flag         = 1'b1;
    end else begin
      ctx_nxt[LAST].fsat = ctx_r[LAST-1].fsat || (|ctx_r[LAST-1].y48[127:101]);
      ctx_nxt[LAST].energy = ctx_r[LAST-1].esat ? OUT_MAX : ctx_r[LAST-1].energy;
      ctx_nxt[LAST].force_factor = ctx_nxt[LAST].fsat ? OUT_MAX
                                                      : ctx_r[LAST-1].y48[100:53];
      ctx_nxt[LAST].flag = ctx_r[LAST-1].esat || ctx_nxt[LAST].fsat;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 1; k <= LAST; k++) begin
        ctx_r[k] <= ctx_nxt[k];
      end
    end
  end

  // Output
  assign out_tdata = {ctx_r[LAST].force_factor, ctx_r[LAST].energy};
  assign out_tuser = ctx_r[LAST].flag;

  // Checks
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("pipeline valid line moved during a stall");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> vld_r == '0)
    else $error("valid line not cleared by reset");

  a_zero_dist_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && ctx_r[LAST].zero) |-> (out_tuser && out_tdata == '1))
    else $error("zero distance did not saturate");

  a_cutoff_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && ctx_r[LAST].skip && !ctx_r[LAST].zero)
      |-> (out_tdata == '0 && !out_tuser))
    else $error("item beyond cutoff gave nonzero result");

endmodule

@@ tb/sv/wca_pair_potential_force_unit_tb.sv @@
// Self-checking testbench for the WCA pair potential/force unit.
// Drives dist_sq items and register writes; predicts energy, force and flag in
// 128-bit arithmetic. Depends on wca_pkg and wca_pair_potential_force_unit.
`timescale 1ns / 1ps

module wca_pair_potential_force_unit_tb;
  import wca_pkg::*;

  localparam int WDOG_LIMIT = 20000;
  // Index past the register list; a write there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_BAD = REG_EPSILON + 8'd1;

  typedef struct packed {
    logic [OUT_W-1:0] energy;
    logic [OUT_W-1:0] force_factor;
    logic             sat;
  } wca_res_t;

  // Directed row: input, and whether a typed-in result applies
  typedef struct {
    logic [31:0] dist_sq;
    bit          fixed;
    wca_res_t    res;
  } dir_row_t;

  logic clk, rst_n;
  logic in_tvalid, in_tready;
  logic [DIST_W-1:0] in_tdata;
  logic out_tvalid, out_tready;
  logic [2*OUT_W-1:0] out_tdata;
  logic out_tuser;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIST_W-1:0] cfg_data;

  logic [31:0] pred_sigma_sq, pred_eps;
  wca_res_t pending_res[$];
  int errors;
  int in_idle_pct, out_idle_pct;
  int wdog;

  wca_pair_potential_force_unit dut (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Q32.32 product with 64-bit overflow flag
  function automatic logic [63:0] q32_mul(input logic [63:0] a, input logic [63:0] b,
                                          inout bit ovf);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    if (p[127:96] != 0) begin
      ovf = 1;
      return '1;
    end
    return p[95:32];
  endfunction

  function automatic wca_res_t wca_predict(input logic [31:0] d);
    wca_res_t r;
    bit s6ovf;
    logic [63:0] q, q2, s6, u, rr, b;
    logic [127:0] x, a, y;
    s6ovf = 0;
    r = '0;
    if (d == 0) begin
      r = '{OUT_MAX, OUT_MAX, 1'b1};
    end else if ({64'd0, d, 24'd0} > 128'(CUT_Q24) * pred_sigma_sq || pred_eps == 0) begin
      r = '0;
    end else begin
      q = {pred_sigma_sq, 32'd0} / {32'd0, d};
      q2 = q32_mul(q, q, s6ovf);
      s6 = s6ovf ? '1 : q32_mul(q2, q, s6ovf);
      if (s6ovf) begin
        r = '{OUT_MAX, OUT_MAX, 1'b1};
      end else begin
        u = (s6 > HALF_Q32) ? s6 - HALF_Q32 : 64'd0;
        // energy: full 128-bit wrap matches the reference product
        x = (({64'd0, u} * {64'd0, u}) >> 32) * pred_eps;
        if (x[127:86] != 0) begin
          r.energy = OUT_MAX;
          r.sat = 1;
        end else r.energy = x[85:38];
        a = (({64'd0, s6} * {64'd0, u}) >> 32) * pred_eps;
        if (a[127:91] != 0) begin
          r.force_factor = OUT_MAX;
          r.sat = 1;
        end else begin
          b = a[90:27];
          rr = 64'hFFFF_FFFF_FFFF_FFFF / {32'd0, d};
          y = {64'd0, b} * {64'd0, rr};
          if (y[127:122] != 0) begin
            r.force_factor = OUT_MAX;
            r.sat = 1;
          end else begin
            y = y * 48;
            if (y[127:101] != 0) begin
              r.force_factor = OUT_MAX;
              r.sat = 1;
            end else r.force_factor = y[100:53];
          end
        end
      end
    end
    return r;
  endfunction

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_SIGMA_SQ) pred_sigma_sq = val;
    else if (idx == REG_EPSILON) pred_eps = val;
  endtask

  task automatic send_dist(input logic [31:0] d, input bit fixed, input wca_res_t res);
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    pending_res.push_back(fixed ? res : wca_predict(d));
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (TOT_LAT + 10) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_dist();
    case ($urandom_range(5))
      0: return $urandom;
      1: return $urandom_range(32'h0300_0000);
      2: return 32'((64'($urandom_range(1500)) * pred_sigma_sq) / 1000
                    + $urandom_range(7));
      3: return $urandom_range(255);
      default: return 32'((64'(pred_sigma_sq) * $urandom_range(700, 1300)) / 1000);
    endcase
  endfunction

  // Receiver side: stall and compare against the oldest expectation
  always @(posedge clk) begin
    wca_res_t got, want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = '{out_tdata[OUT_W-1:0], out_tdata[2*OUT_W-1:OUT_W], out_tuser};
        if (pending_res.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          errors++;
        end else begin
          want = pending_res.pop_front();
          if (got.energy != want.energy) begin
            $display("%0t: energy exp %h act %h", $time, want.energy, got.energy);
            errors++;
          end
          if (got.force_factor != want.force_factor) begin
            $display("%0t: force exp %h act %h", $time, want.force_factor, got.force_factor);
            errors++;
          end
          if (got.sat != want.sat) begin
            $display("%0t: saturated exp %b act %b", $time, want.sat, got.sat);
            errors++;
          end
        end
      end
      out_tready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // Watchdog on cycles with no accepted item
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog >= WDOG_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    dir_row_t rows[$];
    logic [31:0] sig_set[5], eps_set[5];
    errors = 0;
    wdog = 0;
    in_idle_pct = 17;
    out_idle_pct = 60;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    pred_sigma_sq = 32'h0100_0000;
    pred_eps = 32'h0100_0000;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows under reset registers (sigma^2 = eps = 1.0)
    rows.push_back('{32'd0, 1, '{OUT_MAX, OUT_MAX, 1'b1}});       // zero distance
    rows.push_back('{32'hFFFF_FFFF, 1, '{48'd0, 48'd0, 1'b0}});   // far beyond cutoff
    rows.push_back('{32'h0200_0000, 1, '{48'd0, 48'd0, 1'b0}});   // r^2 = 2
    rows.push_back('{32'd1, 0, '0});                              // s6 overflow
    rows.push_back('{32'h0001_0000, 0, '0});
    rows.push_back('{32'h0080_0000, 0, '0});
    rows.push_back('{32'h0100_0000, 0, '0});                      // r = sigma
    rows.push_back('{32'h0142_8A2F, 0, '0});                      // at cutoff
    rows.push_back('{32'h0142_8A2E, 0, '0});                      // just inside
    rows.push_back('{32'h0142_8A30, 0, '0});                      // just outside
    rows.push_back('{32'h00C0_0000, 0, '0});
    rows.push_back('{32'h5555_5555, 0, '0});
    rows.push_back('{32'hAAAA_AAAA, 0, '0});
    foreach (rows[i]) send_dist(rows[i].dist_sq, rows[i].fixed, rows[i].res);
    drain_results();

    // Zero epsilon inside cutoff, huge sigma, write past the list, zero sigma
    cfg_write(REG_EPSILON, 32'd0);
    send_dist(32'h0100_0000, 1, '{48'd0, 48'd0, 1'b0});
    drain_results();
    cfg_write(REG_EPSILON, 32'hFFFF_FFFF);
    cfg_write(REG_SIGMA_SQ, 32'hFFFF_FFFF);
    send_dist(32'hFFFF_FFFF, 0, '0);
    send_dist(32'hCB00_0000, 0, '0);
    send_dist(32'h8000_0000, 0, '0);
    drain_results();
    cfg_write(REG_BAD, 32'h1234_5678);
    send_dist(32'h8000_0000, 0, '0);
    drain_results();
    cfg_write(REG_SIGMA_SQ, 32'd0);
    send_dist(32'd5, 1, '{48'd0, 48'd0, 1'b0});
    drain_results();

    // Random phases over a spread of register settings
    sig_set = '{32'h0100_0000, 32'hFFFF_FFFF, 32'h0000_4000, 32'h0400_0000, 32'd0};
    eps_set = '{32'h0100_0000, 32'hFFFF_FFFF, 32'd1, 32'h0000_1000, 32'h00FF_FFFF};
    for (int ph = 0; ph < 11; ph++) begin
      if (ph == 4) begin
        in_idle_pct = 60;
        out_idle_pct = 17;
      end else if (ph == 8) begin
        in_idle_pct = 0;
        out_idle_pct = 0;
      end
      if (ph < 10) begin
        cfg_write(REG_SIGMA_SQ, (ph < 5) ? sig_set[ph] : $urandom);
        cfg_write(REG_EPSILON, (ph < 5) ? eps_set[ph] : $urandom);
      end
      for (int n = 0; n < 100; n++) send_dist(rand_dist(), 0, '0);
      drain_results();
    end

    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

@@ filelist.f @@
src/wca_pkg.sv
src/wca_mul.sv
src/wca_div.sv
src/wca_pair_potential_force_unit.sv
tb/sv/wca_pair_potential_force_unit_tb.sv
